// ===== src/wps_pkg.sv =====
// ----------------------------------------------------------------------------
// wps_pkg
// Types and constants shared by the WAV PCM16 stream parser.
// ----------------------------------------------------------------------------
package wps_pkg;

    localparam logic [31:0] MAGIC_RIFF = 32'h5249_4646;
    localparam logic [31:0] MAGIC_WAVE = 32'h5741_5645;
    localparam logic [31:0] ID_FMT     = 32'h666d_7420;
    localparam logic [31:0] ID_DATA    = 32'h6461_7461;
    localparam logic [31:0] PCM_TAG    = 32'd1;
    localparam logic [31:0] PCM_BITS   = 32'd16;

    localparam int          QUEUE_DEPTH       = 4;
    localparam logic [31:0] FRAME_LIMIT_RESET = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        EV_SAMPLE = 2'd0,
        EV_FORMAT = 2'd1,
        EV_ERROR  = 2'd2
    } t_event_kind;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_RIFF     = 3'd1,
        ERR_WAVE     = 3'd2,
        ERR_NOT_PCM  = 3'd3,
        ERR_NOT_16   = 3'd4,
        ERR_DATA_1ST = 3'd5,
        ERR_NO_FMT   = 3'd6,
        ERR_NO_DATA  = 3'd7
    } t_error_code;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         event_kind;
        logic signed [15:0] sample_value;
        logic [15:0]        channel_index;
        logic               last_sample;
        logic [15:0]        channel_count;
        logic [31:0]        rate_hz;
        logic [2:0]         error_code;
    } t_out_item;

endpackage

// ===== src/wps_div.sv =====
// ----------------------------------------------------------------------------
// wps_div
// Restoring divider, one quotient bit per cycle (32 by 16 bits).
// ----------------------------------------------------------------------------
module wps_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);
    logic [31:0] r_q;
    logic [15:0] r_rem;
    logic [15:0] r_dvs;
    logic [4:0]  r_step;
    logic        r_busy;
    logic        r_done;

    logic [16:0] s_trial;
    logic        s_ge;

    assign s_trial = {r_rem, r_q[31]};
    assign s_ge    = s_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 5'd1;
            if (r_step == 5'd31) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so 16 bits hold it
            r_rem <= s_ge ? 16'(s_trial - {1'b0, r_dvs}) : s_trial[15:0];
            r_q   <= {r_q[30:0], s_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule

// ===== src/wps_fifo.sv =====
// ----------------------------------------------------------------------------
// wps_fifo
// Short event queue between the parser front and the output channel.
// ----------------------------------------------------------------------------
module wps_fifo #(
    parameter int DEPTH = wps_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  wps_pkg::t_out_item i_data,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_stall,
    output wps_pkg::t_out_item o_data
);
    import wps_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_out_item         r_mem [DEPTH];
    logic [AW-1:0]     r_wp;
    logic [AW-1:0]     r_rp;
    logic [CW-1:0]     r_cnt;
    logic              s_pop;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign s_pop   = o_valid && !i_stall;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            if (s_pop)  r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            r_cnt <= r_cnt + CW'(i_push) - CW'(s_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into full queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH)) else $error("queue count out of range");
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == CW'(1) && s_pop && !i_push) |=> !o_valid)
        else $error("queue not empty after last pop");
    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wp == r_rp)) else $error("pointers differ when empty");
`endif
endmodule

// ===== src/wps_front.sv =====
// ----------------------------------------------------------------------------
// wps_front
// Byte parser: walks the RIFF/WAVE structure and produces events.
// ----------------------------------------------------------------------------
module wps_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  wps_pkg::t_in_item  i_in,
    input  logic [31:0]        i_frame_limit,
    input  logic               i_q_full,
    output logic               o_push,
    output wps_pkg::t_out_item o_event
);
    import wps_pkg::*;

    typedef enum logic [15:0] {
        PH_RIFF   = 16'h0001,
        PH_RSIZE  = 16'h0002,
        PH_WAVE   = 16'h0004,
        PH_CID    = 16'h0008,
        PH_CSIZE  = 16'h0010,
        PH_FTAG   = 16'h0020,
        PH_FCH    = 16'h0040,
        PH_FRATE  = 16'h0080,
        PH_FBR    = 16'h0100,
        PH_FALIGN = 16'h0200,
        PH_FBITS  = 16'h0400,
        PH_SKIP   = 16'h0800,
        PH_DIV    = 16'h1000,
        PH_DATA   = 16'h2000,
        PH_DONE   = 16'h4000,
        PH_ERR    = 16'h8000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_bif, n_bif;
    logic [31:0] r_field, n_field;
    logic [31:0] r_riff, n_riff;
    logic [31:0] r_chunk, n_chunk;
    logic [31:0] r_kind, n_kind;
    logic        r_fmt, n_fmt;
    logic [15:0] r_chans, n_chans;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_align, n_align;
    logic [31:0] r_fdone, n_fdone;
    logic [15:0] r_chan, n_chan;
    logic [7:0]  r_low, n_low;

    logic        s_accept;
    logic        s_div_start;
    logic        s_div_done;
    logic [31:0] s_quot;
    logic [31:0] s_div_num;

    assign o_in_stall = i_q_full || (r_phase == PH_DIV);
    assign s_accept   = i_in_valid && !o_in_stall;

    wps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_div_start),
        .i_dividend (s_div_num),
        .i_divisor  (r_align),
        .o_done     (s_div_done),
        .o_quotient (s_quot)
    );

    always_comb begin
        t_phase      c_phase;
        logic [1:0]  c_bif;
        logic [31:0] c_field;
        logic [31:0] nf_le;
        logic [31:0] nf_be;
        logic [31:0] riff_dec;
        logic [31:0] chunk_dec;
        logic [31:0] frames;
        logic        done_le;
        logic        err_v;
        logic [2:0]  err_c;
        logic        bnd;
        logic        frame_end;

        n_phase = r_phase;  n_bif = r_bif;     n_field = r_field;
        n_riff  = r_riff;   n_chunk = r_chunk; n_kind = r_kind;
        n_fmt   = r_fmt;    n_chans = r_chans; n_rate = r_rate;
        n_align = r_align;  n_fdone = r_fdone; n_chan = r_chan;
        n_low   = r_low;
        o_push  = 1'b0;
        o_event = '0;
        s_div_start = 1'b0;
        s_div_num   = '0;
        err_v = 1'b0;
        err_c = ERR_NONE;
        bnd   = 1'b0;
        frames = '0;
        frame_end = 1'b0;

        // restart needs only these; everything else is rewritten before use
        c_phase = i_in.start_of_file ? PH_RIFF : r_phase;
        c_bif   = i_in.start_of_file ? 2'd0 : r_bif;
        c_field = i_in.start_of_file ? 32'd0 : r_field;
        if (s_accept && i_in.start_of_file) n_fmt = 1'b0;

        nf_le     = c_field | ({24'd0, i_in.data_byte} << {c_bif, 3'b000});
        nf_be     = {c_field[23:0], i_in.data_byte};
        riff_dec  = (r_riff  != '0) ? r_riff  - 32'd1 : 32'd0;
        chunk_dec = (r_chunk != '0) ? r_chunk - 32'd1 : 32'd0;
        done_le   = ((c_phase == PH_FRATE) || (c_phase == PH_FBR) ||
                     (c_phase == PH_RSIZE) || (c_phase == PH_CSIZE))
                    ? (c_bif == 2'd3) : (c_bif == 2'd1);

        if (r_phase == PH_DIV) begin
            if (s_div_done && !i_q_full) begin
                frames = (r_align == '0) ? 32'd0 : s_quot;
                if (frames > i_frame_limit) frames = i_frame_limit;
                n_chunk = frames;
                n_fdone = '0;
                n_chan  = '0;
                n_phase = (frames == '0 || r_chans == '0) ? PH_DONE : PH_DATA;
                o_push  = 1'b1;
                o_event.event_kind    = EV_FORMAT;
                o_event.channel_count = r_chans;
                o_event.rate_hz       = r_rate;
            end
        end else if (s_accept) begin
            n_phase = c_phase;
            n_bif   = c_bif;
            n_field = c_field;
            unique case (c_phase)
                PH_RIFF: begin
                    n_field = nf_be;
                    if (c_bif == 2'd3) begin
                        n_bif = '0; n_field = '0;
                        if (nf_be != MAGIC_RIFF) begin
                            err_v = 1'b1; err_c = ERR_RIFF;
                        end else n_phase = PH_RSIZE;
                    end else n_bif = c_bif + 2'd1;
                end
                PH_RSIZE: begin
                    n_field = nf_le;
                    if (done_le) begin
                        n_bif = '0; n_field = '0; n_riff = nf_le; n_phase = PH_WAVE;
                    end else n_bif = c_bif + 2'd1;
                end
                PH_WAVE: begin
                    n_riff  = riff_dec;
                    n_field = nf_be;
                    if (c_bif == 2'd3) begin
                        n_bif = '0; n_field = '0;
                        if (nf_be != MAGIC_WAVE) begin
                            err_v = 1'b1; err_c = ERR_WAVE;
                        end else bnd = 1'b1;
                    end else n_bif = c_bif + 2'd1;
                end
                PH_CID: begin
                    n_riff  = riff_dec;
                    n_field = nf_be;
                    if (c_bif == 2'd3) begin
                        n_bif = '0; n_field = '0; n_kind = nf_be; n_phase = PH_CSIZE;
                    end else n_bif = c_bif + 2'd1;
                end
                PH_CSIZE: begin
                    n_riff  = riff_dec;
                    n_field = nf_le;
                    if (done_le) begin
                        n_bif = '0; n_field = '0; n_chunk = nf_le;
                        if (r_kind == ID_FMT) begin
                            n_fmt = 1'b1; n_phase = PH_FTAG;
                        end else if (r_kind == ID_DATA) begin
                            if (!r_fmt || i_in.start_of_file) begin
                                err_v = 1'b1; err_c = ERR_DATA_1ST;
                            end else begin
                                s_div_start = 1'b1;
                                s_div_num   = nf_le;
                                n_phase     = PH_DIV;
                            end
                        end else if (nf_le == '0) bnd = 1'b1;
                        else n_phase = PH_SKIP;
                    end else n_bif = c_bif + 2'd1;
                end
                PH_FTAG, PH_FCH, PH_FRATE, PH_FBR, PH_FALIGN, PH_FBITS: begin
                    n_riff  = riff_dec;
                    n_chunk = chunk_dec;
                    n_field = nf_le;
                    if (done_le) begin
                        n_bif = '0; n_field = '0;
                        priority case (c_phase)
                            PH_FTAG: begin
                                if (nf_le != PCM_TAG) begin
                                    err_v = 1'b1; err_c = ERR_NOT_PCM;
                                end else n_phase = PH_FCH;
                            end
                            PH_FCH: begin
                                n_chans = nf_le[15:0]; n_phase = PH_FRATE;
                            end
                            PH_FRATE: begin
                                n_rate = nf_le; n_phase = PH_FBR;
                            end
                            PH_FBR: n_phase = PH_FALIGN;
                            PH_FALIGN: begin
                                n_align = nf_le[15:0]; n_phase = PH_FBITS;
                            end
                            default: begin
                                if (nf_le != PCM_BITS) begin
                                    err_v = 1'b1; err_c = ERR_NOT_16;
                                end else if (chunk_dec == '0) bnd = 1'b1;
                                else n_phase = PH_SKIP;
                            end
                        endcase
                    end else n_bif = c_bif + 2'd1;
                end
                PH_SKIP: begin
                    n_riff  = riff_dec;
                    n_chunk = chunk_dec;
                    if (chunk_dec == '0) bnd = 1'b1;
                end
                PH_DATA: begin
                    if (c_bif == 2'd0) begin
                        n_low = i_in.data_byte;
                        n_bif = 2'd1;
                    end else begin
                        n_bif = '0;
                        frame_end = ({1'b0, r_chan} + 17'd1) >= {1'b0, r_chans};
                        o_push = 1'b1;
                        o_event.event_kind    = EV_SAMPLE;
                        o_event.sample_value  = {i_in.data_byte, r_low};
                        o_event.channel_index = r_chan;
                        o_event.last_sample   = frame_end &&
                                                (r_fdone + 32'd1 == r_chunk);
                        o_event.channel_count = r_chans;
                        o_event.rate_hz       = r_rate;
                        if (frame_end) begin
                            n_chan  = '0;
                            n_fdone = r_fdone + 32'd1;
                            if (r_fdone + 32'd1 >= r_chunk) n_phase = PH_DONE;
                        end else n_chan = r_chan + 16'd1;
                    end
                end
                default: ; // done, error: bytes dropped until restart
            endcase

            if (bnd) begin
                if (riff_dec == '0) begin
                    err_v = 1'b1;
                    err_c = n_fmt ? ERR_NO_DATA : ERR_NO_FMT;
                end else n_phase = PH_CID;
            end
            if (err_v) begin
                n_phase = PH_ERR;
                o_push  = 1'b1;
                o_event = '0;
                o_event.event_kind = EV_ERROR;
                o_event.error_code = err_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RIFF;
            r_bif   <= '0;
            r_field <= '0;
            r_fmt   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_bif   <= n_bif;
            r_field <= n_field;
            r_fmt   <= n_fmt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_riff  <= n_riff;
        r_chunk <= n_chunk;
        r_kind  <= n_kind;
        r_chans <= n_chans;
        r_rate  <= n_rate;
        r_align <= n_align;
        r_fdone <= n_fdone;
        r_chan  <= n_chan;
        r_low   <= n_low;
    end

`ifndef SYNTHESIS
    a_div_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DIV) |-> o_in_stall) else $error("byte taken during divide");
    a_one_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && r_phase != PH_DIV) |-> s_accept) else $error("event without byte");
    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ERR && !i_in.start_of_file) |-> !o_push)
        else $error("event after error");
`endif
endmodule

// ===== src/wav_pcm16_stream_parser_top.sv =====
// ----------------------------------------------------------------------------
// wav_pcm16_stream_parser_top
// WAV file byte stream in, format/sample/error events out.
// ----------------------------------------------------------------------------
// Input channel: one file byte per beat (i_in_valid / o_in_stall); set
// start_of_file on the first byte of a file to restart the parse.
// Output channel: one event per beat (o_out_valid / i_out_stall): a format
// event at the data chunk, then samples with channel index, the final one
// flagged, or a single error event after which bytes are dropped.
// Config channel: i_cfg_valid / o_cfg_ready writes frame_limit; ready is
// always high. Write it only while the block is idle.
// Throughput: one byte per cycle while the queue has room. After the data
// chunk header the input stalls while the serial divider (one bit a cycle)
// works out the frame count from the size and block align.
// Events: a sample or error event enters the queue in the cycle the byte
// that caused it is taken; the format event enters once the divider is
// done and the queue has room. A four-entry queue decouples the sides:
// a stalled receiver holds the current event, and the input stalls when
// the queue is full or while the divider works.
// Reset (synchronous, active low) empties the queue, restarts the parse and
// sets frame_limit to all ones.
// ----------------------------------------------------------------------------
module wav_pcm16_stream_parser_top #(
    parameter int QDEPTH = wps_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  wps_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output wps_pkg::t_out_item o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data
);
    import wps_pkg::*;

    logic [31:0] r_frame_limit;
    logic        s_full;
    logic        s_push;
    t_out_item   s_event;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_frame_limit <= FRAME_LIMIT_RESET;
        else if (i_cfg_valid) r_frame_limit <= i_cfg_data;
    end

    wps_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in          (i_in),
        .i_frame_limit (r_frame_limit),
        .i_q_full      (s_full),
        .o_push        (s_push),
        .o_event       (s_event)
    );

    wps_fifo #(.DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_data  (s_event),
        .o_full  (s_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out)
    );
endmodule
